[sv/plbo_pkg.sv]
// ----------------------------------------------------------------------------
// plbo_pkg: shared types and constants
// Break record layout, sequencer states, line cost unit interface.
// ----------------------------------------------------------------------------
package plbo_pkg;

	localparam int X_W    = 16;
	localparam int DATA_W = 50;
	localparam int PRED_W = 7;
	localparam int LC_W   = 40;

	localparam logic [PRED_W-1:0] START_MARK = 7'd127;

	localparam logic [1:0] CFG_START_OFFSET = 2'd0;
	localparam logic [1:0] CFG_IDEAL_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HYPHEN_PAIR  = 2'd2;

	// flags: bit0 hyphen, bit1 hard break
	typedef struct packed {
		logic [1:0]     flags;
		logic [X_W-1:0] pen;
		logic [X_W-1:0] sx;
		logic [X_W-1:0] ex;
	} brk_t;

	typedef struct packed {
		logic           u_start;
		logic [X_W-1:0] start_u;
		logic           hyp_u;
		logic [X_W-1:0] end_v;
		logic [X_W-1:0] pen_v;
		logic [1:0]     flags_v;
	} lc_req_t;

	typedef struct packed {
		logic            fit;
		logic            zero;
		logic [LC_W-1:0] w;
	} lc_res_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_R_ISSUE,
		ST_R_EVAL,
		ST_R_MUL,
		ST_R_UPD,
		ST_R_END,
		ST_TAKE,
		ST_TAKE_FIN,
		ST_TAKE_DEC,
		ST_U_RD,
		ST_U_LD,
		ST_BT_RD,
		ST_BT_CHK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

[sv/plbo_ram.sv]
// ----------------------------------------------------------------------------
// plbo_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plbo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[sv/plbo_line_cost.sv]
// ----------------------------------------------------------------------------
// plbo_line_cost: shared line cost unit
// Stage 1 forms width, fit and slack magnitude; stage 2 squares it.
// ----------------------------------------------------------------------------
module plbo_line_cost (
	input  logic                    clk,
	input  plbo_pkg::lc_req_t       req,
	input  logic [15:0]             start_off,
	input  logic [14:0]             ideal,
	input  logic [14:0]             hpp,
	output plbo_pkg::lc_res_t       res
);
	import plbo_pkg::*;

	logic signed [16:0] start_c;
	logic signed [17:0] width_c;
	logic signed [20:0] slack_c;
	logic               pair_c;
	logic               fit_c;
	logic [19:0]        mag_c;

	logic        fit_s1, hard_s1;
	logic [19:0] mag_s1;
	logic        fit_s2, zero_s2;
	logic [LC_W-1:0] w_s2;

	always_comb begin
		start_c = req.u_start ? (17'sd0 - $signed({start_off[15], start_off}))
		                      : $signed({req.start_u[15], req.start_u});
		width_c = $signed({{2{req.end_v[15]}}, req.end_v}) - $signed({start_c[16], start_c});
		fit_c   = $signed({3'b000, ideal}) >= width_c;
		pair_c  = !req.u_start && req.hyp_u && req.flags_v[0];
		slack_c = $signed({6'b0, ideal}) - $signed({{3{width_c[17]}}, width_c})
		        + $signed({{5{req.pen_v[15]}}, req.pen_v})
		        + (pair_c ? $signed({6'b0, hpp}) : 21'sd0);
		mag_c   = slack_c[20] ? 20'(-slack_c) : 20'(slack_c);
	end

	always_ff @(posedge clk) begin
		fit_s1  <= fit_c;
		hard_s1 <= req.flags_v[1];
		mag_s1  <= mag_c;
		fit_s2  <= fit_s1;
		zero_s2 <= hard_s1 || (mag_s1 == 20'd0);
		w_s2    <= hard_s1 ? '0 : mag_s1 * mag_s1;
	end

	assign res.fit  = fit_s2;
	assign res.zero = zero_s2;
	assign res.w    = w_s2;

endmodule

[sv/paragraph_line_break_optimizer_top.sv]
// ----------------------------------------------------------------------------
// paragraph_line_break_optimizer_top: minimum raggedness line breaker
// Loads break beats, solves shortest path with one line cost unit, emits breaks.
// ----------------------------------------------------------------------------
// Load: one beat per cycle until the beat with tlast; then the block is busy.
// Solve: each edge is relaxed through the line cost unit; each extraction scans
//   the cost RAM for the cheapest unvisited node and fetches its record; the
//   path is then backtracked and emitted. Relaxing, extraction and backtrack are
//   paced by the single line cost unit and the single read port of the cost RAM.
// Reset (arst_n low): sequencer idle and ready, registers to defaults, no beat out.
// ----------------------------------------------------------------------------
module paragraph_line_break_optimizer_top #(
	parameter int MAX_BREAKS = 64,
	parameter int COST_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// input break beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // line_end_x, next_start_x, break_penalty
	input  logic [1:0]  s_tuser,  // is_hyphen, is_hard_break
	input  logic        s_tlast,  // last_break
	// chosen break beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // break_index, zero pad
	output logic        m_tlast,  // last_of_run
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import plbo_pkg::*;

	localparam int IW  = $clog2(MAX_BREAKS);
	localparam int NW  = IW + 1;
	localparam int CPW = COST_WIDTH + PRED_W;
	localparam logic [COST_WIDTH-1:0] COST_INF = {COST_WIDTH{1'b1}};
	localparam logic [COST_WIDTH-1:0] COST_CAP = COST_INF - 1'b1;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_BREAKS);

	// configuration registers
	logic [15:0] start_off_q;
	logic [14:0] ideal_q, hpp_q;

	state_t state_q, state_d;

	logic [NW-1:0] total_q, n_q, len_q;
	logic [IW-1:0] u_q, v_q, t_q, cur_q, emit_q, best_idx_q, tk_idx_s1;
	logic          u_start_q, found_q, have_best_q, tk_vld_s1, rd_vld_q;
	logic [15:0]   start_u_q;
	logic          hyp_u_q;
	logic [COST_WIDTH-1:0] base_q, best_c_q;
	logic [MAX_BREAKS-1:0] visited_q, cost_vld_q;
	logic          m_tvalid_q, m_last_q;
	logic [5:0]    m_data_q;

	// RAM ports
	logic           data_we, data_re;
	logic [IW-1:0]  data_waddr, data_raddr;
	brk_t           data_wdata, data_rdata;
	logic           cost_we, cost_re;
	logic [IW-1:0]  cost_waddr, cost_raddr;
	logic [CPW-1:0] cost_wdata, cost_rdata;
	logic           path_we, path_re;
	logic [IW-1:0]  path_waddr, path_raddr;
	logic [IW-1:0]  path_wdata, path_rdata;

	lc_req_t lc_req;
	lc_res_t lc_res;

	logic                  in_acc, solve_go, emit_load;
	logic [NW-1:0]         n_new, n_m1, up1;
	logic [PRED_W-1:0]     mark, bt_pred;
	logic [COST_WIDTH-1:0] cur_cost, w_ext, total_c, tk_cost;
	logic                  sat, upd, scan_done, tk_take, bt_stop;

	plbo_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BREAKS)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.re(data_re), .raddr(data_raddr), .rdata(data_rdata)
	);

	// best cost and predecessor share one word; per-entry valid bits stand in for
	// the infinity / start marker reset
	plbo_ram #(.WIDTH(CPW), .DEPTH(MAX_BREAKS)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata)
	);

	// backtracked path, read back in reverse for ascending output
	plbo_ram #(.WIDTH(IW), .DEPTH(MAX_BREAKS)) u_path_ram (
		.clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
		.re(path_re), .raddr(path_raddr), .rdata(path_rdata)
	);

	assign lc_req.u_start = u_start_q;
	assign lc_req.start_u = start_u_q;
	assign lc_req.hyp_u   = hyp_u_q;
	assign lc_req.end_v   = data_rdata.ex;
	assign lc_req.pen_v   = data_rdata.pen;
	assign lc_req.flags_v = data_rdata.flags;

	plbo_line_cost u_line_cost (
		.clk(clk), .req(lc_req), .start_off(start_off_q),
		.ideal(ideal_q), .hpp(hpp_q), .res(lc_res)
	);

	// datapath terms
	always_comb begin
		in_acc    = s_tvalid && s_tready;
		solve_go  = in_acc && s_tlast;
		n_new     = (total_q < MAX_N) ? total_q + 1'b1 : total_q;
		n_m1      = n_q - 1'b1;
		up1       = u_start_q ? '0 : {1'b0, u_q} + 1'b1;
		mark      = u_start_q ? START_MARK : PRED_W'(u_q);
		cur_cost  = rd_vld_q ? cost_rdata[COST_WIDTH-1:0] : COST_INF;
		w_ext     = COST_WIDTH'(lc_res.w);
		// saturating add, cap is one below infinity
		sat       = (base_q >= COST_CAP) || (w_ext >= COST_CAP - base_q);
		total_c   = sat ? COST_CAP : base_q + w_ext;
		upd       = lc_res.fit && (cur_cost > total_c);
		scan_done = !lc_res.fit || lc_res.zero || (v_q == n_m1[IW-1:0]);
		tk_cost   = cur_cost;
		tk_take   = tk_vld_s1 && !visited_q[tk_idx_s1] && (tk_cost < COST_INF)
		          && (!have_best_q || (tk_cost < best_c_q));
		bt_pred   = rd_vld_q ? cost_rdata[CPW-1 -: PRED_W] : START_MARK;
		bt_stop   = (len_q + 1'b1 >= n_q) || (bt_pred >= PRED_W'(cur_q));
		emit_load = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (solve_go) state_d = ST_R_ISSUE;
			ST_R_ISSUE:  state_d = ST_R_EVAL;
			ST_R_EVAL:   state_d = ST_R_MUL;
			ST_R_MUL:    state_d = ST_R_UPD;
			ST_R_UPD:    state_d = scan_done ? ST_R_END : ST_R_ISSUE;
			ST_R_END:    state_d = ST_TAKE;
			ST_TAKE:     if (t_q == n_m1[IW-1:0]) state_d = ST_TAKE_FIN;
			ST_TAKE_FIN: state_d = ST_TAKE_DEC;
			ST_TAKE_DEC: state_d = have_best_q ? ST_U_RD : ST_BT_RD;
			ST_U_RD:     state_d = ST_U_LD;
			ST_U_LD:     state_d = (up1 < n_q) ? ST_R_ISSUE : ST_R_END;
			ST_BT_RD:    state_d = ST_BT_CHK;
			ST_BT_CHK:   state_d = bt_stop ? ST_EMIT_RD : ST_BT_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (emit_load)
					state_d = (emit_q == '0) ? ST_LOAD : ST_EMIT_RD;
			end
			default:     state_d = ST_LOAD;
		endcase
	end

	// memory controls
	always_comb begin
		s_tready   = (state_q == ST_LOAD);
		data_we    = in_acc && (total_q < MAX_N);
		data_waddr = total_q[IW-1:0];
		data_wdata = '{flags: s_tuser, pen: s_tdata[47:32], sx: s_tdata[31:16],
		               ex: s_tdata[15:0]};
		data_re    = (state_q == ST_R_ISSUE) || (state_q == ST_U_RD);
		data_raddr = (state_q == ST_U_RD) ? u_q : v_q;

		cost_re    = 1'b0;
		cost_raddr = v_q;
		case (state_q)
			ST_R_ISSUE: begin cost_re = 1'b1; cost_raddr = v_q;   end
			ST_TAKE:    begin cost_re = 1'b1; cost_raddr = t_q;   end
			ST_BT_RD:   begin cost_re = 1'b1; cost_raddr = cur_q; end
			default:    cost_re = 1'b0;
		endcase

		cost_we    = 1'b0;
		cost_waddr = v_q;
		cost_wdata = {mark, total_c};
		case (state_q)
			ST_R_UPD: cost_we = upd;
			ST_R_END: begin
				// no line fits: force the overlong line to the next break
				cost_we    = !found_q && (up1 < n_q);
				cost_waddr = up1[IW-1:0];
				cost_wdata = {mark, base_q};
			end
			default:  cost_we = 1'b0;
		endcase

		path_we    = (state_q == ST_BT_CHK);
		path_waddr = len_q[IW-1:0];
		path_wdata = cur_q;
		path_re    = (state_q == ST_EMIT_RD);
		path_raddr = emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_off_q <= '0;
			ideal_q     <= 15'd4800;
			hpp_q       <= '0;
			state_q     <= ST_LOAD;
			total_q     <= '0;
			visited_q   <= '0;
			cost_vld_q  <= '0;
			tk_vld_s1   <= 1'b0;
			have_best_q <= 1'b0;
			rd_vld_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_OFFSET: start_off_q <= cfg_data;
					CFG_IDEAL_WIDTH:  ideal_q     <= cfg_data[14:0];
					CFG_HYPHEN_PAIR:  hpp_q       <= cfg_data[14:0];
					default:          ;
				endcase
			end
			state_q <= state_d;
			if (cost_re)
				rd_vld_q <= cost_vld_q[cost_raddr];
			if (cost_we)
				cost_vld_q[cost_waddr] <= 1'b1;
			tk_vld_s1 <= (state_q == ST_TAKE);
			tk_idx_s1 <= t_q;
			if (tk_take) begin
				have_best_q <= 1'b1;
				best_idx_q  <= tk_idx_s1;
				best_c_q    <= tk_cost;
			end
			// in the emit step a taken beat is replaced by the next one below
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT_LD))
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_LOAD: begin
					if (solve_go) begin
						total_q    <= '0;
						n_q        <= n_new;
						visited_q  <= '0;
						cost_vld_q <= '0;
						u_start_q  <= 1'b1;
						v_q        <= '0;
						base_q     <= '0;
						found_q    <= 1'b0;
					end else if (data_we) begin
						total_q <= total_q + 1'b1;
					end
				end
				ST_R_UPD: begin
					if (lc_res.fit)
						found_q <= 1'b1;
					v_q <= v_q + 1'b1;
				end
				ST_R_END: begin
					t_q         <= '0;
					have_best_q <= 1'b0;
				end
				ST_TAKE:  t_q <= t_q + 1'b1;
				ST_TAKE_DEC: begin
					if (have_best_q) begin
						visited_q[best_idx_q] <= 1'b1;
						u_q       <= best_idx_q;
						u_start_q <= 1'b0;
						base_q    <= best_c_q;
					end else begin
						cur_q <= n_m1[IW-1:0];
						len_q <= '0;
					end
				end
				ST_U_LD: begin
					start_u_q <= data_rdata.sx;
					hyp_u_q   <= data_rdata.flags[0];
					v_q       <= up1[IW-1:0];
					found_q   <= 1'b0;
				end
				ST_BT_CHK: begin
					len_q <= len_q + 1'b1;
					if (bt_stop)
						emit_q <= len_q[IW-1:0];
					else
						cur_q <= bt_pred[IW-1:0];
				end
				ST_EMIT_LD: begin
					if (emit_load) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= 6'(path_rdata);
						m_last_q   <= (emit_q == '0);
						emit_q     <= emit_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_data_q};
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	// the final beat of a paragraph starts the solve and drops ready
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("ready still high after final break beat");

	// load counter never runs past the store
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MAX_N)
		else $error("break count beyond store depth");

	// output beats come only from the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT_LD))
		else $error("output beat outside emit");

	// input is only taken while no solve is running
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cost_we && !path_we)
		else $error("ready while solving");
`endif

endmodule

[dv/plbo_break_checker.sv]
// ----------------------------------------------------------------------------
// plbo_break_checker: predicts and checks chosen line breaks
// Tracks accepted break beats and register writes, solves each paragraph for
// its cheapest break path and compares every output beat against the result.
// ----------------------------------------------------------------------------
module plbo_break_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import plbo_pkg::*;

	localparam int                 DEPTH    = 64;
	localparam logic [63:0]        COST_INF = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct {
		logic [5:0] idx;
		logic       last;
	} pick_t;

	logic [15:0] offset_r;
	logic [14:0] ideal_r;
	logic [14:0] hyp_pen_r;

	brk_t        para[DEPTH];
	int          para_len;
	logic [63:0] path_cost[DEPTH];
	int          path_from[DEPTH];
	bit          settled[DEPTH];
	pick_t       picks[$];

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] cap;
		cap = COST_INF - 64'd1;
		if (a >= cap || b >= cap - a)
			return cap;
		return a + b;
	endfunction

	// cost of the line from break u (or the paragraph start when u < 0) to v
	function bit line_cost_of(int u, int v, output logic [63:0] w);
		longint from_x, wid, slack, ideal;
		ideal  = longint'({1'b0, ideal_r});
		from_x = (u < 0) ? -sx16(offset_r) : sx16(para[u].sx);
		wid    = sx16(para[v].ex) - from_x;
		w      = '0;
		if (ideal < wid)
			return 0;
		if (para[v].flags[1])
			return 1;
		slack = ideal - wid + sx16(para[v].pen);
		if (u >= 0 && para[u].flags[0] && para[v].flags[0])
			slack += longint'({1'b0, hyp_pen_r});
		if (slack < 0)
			slack = -slack;
		w = slack * slack;
		return 1;
	endfunction

	function void relax_from(int u);
		logic [63:0] base, w, total;
		bit          any;
		int          v;
		base = (u < 0) ? 64'd0 : path_cost[u];
		any  = 0;
		for (v = u + 1; v < para_len; v++) begin
			if (!line_cost_of(u, v, w))
				break;
			total = sat_add(base, w);
			if (path_cost[v] > total) begin
				path_cost[v] = total;
				path_from[v] = (u < 0) ? int'(START_MARK) : u;
			end
			any = 1;
			if (w == 0)
				break;
		end
		// nothing fits: force an overlong line to the next break
		if (!any && u + 1 < para_len) begin
			path_cost[u+1] = base;
			path_from[u+1] = (u < 0) ? int'(START_MARK) : u;
		end
	endfunction

	function int take_least();
		int best, i;
		best = -1;
		for (i = 0; i < para_len; i++) begin
			if (settled[i] || path_cost[i] >= COST_INF)
				continue;
			if (best < 0 || path_cost[i] < path_cost[best])
				best = i;
		end
		if (best >= 0)
			settled[best] = 1;
		return best;
	endfunction

	function automatic void solve_paragraph();
		int    u, cur, cnt, k;
		int    chain[$];
		pick_t p;
		for (k = 0; k < DEPTH; k++) begin
			path_cost[k] = COST_INF;
			path_from[k] = int'(START_MARK);
			settled[k]   = 0;
		end
		u = -1;
		do begin
			relax_from(u);
			u = take_least();
		end while (u != -1);
		cur = para_len - 1;
		cnt = 0;
		while (cnt < para_len) begin
			chain.push_front(cur);
			cnt++;
			if (path_from[cur] >= cur)
				break;
			cur = path_from[cur];
		end
		for (k = 0; k < chain.size(); k++) begin
			p.idx  = chain[k][5:0];
			p.last = (k == chain.size() - 1);
			picks.push_back(p);
		end
	endfunction

	task report(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t exp_pick;
		if (!arst_n) begin
			offset_r   <= '0;
			ideal_r    <= 15'd4800;
			hyp_pen_r  <= '0;
			para_len   = 0;
			picks.delete();
			pending    <= 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_OFFSET: offset_r  <= cfg_data;
					CFG_IDEAL_WIDTH:  ideal_r   <= cfg_data[14:0];
					CFG_HYPHEN_PAIR:  hyp_pen_r <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				// beats past the store depth are dropped, tlast still solves
				if (para_len < DEPTH) begin
					para[para_len].ex    = s_tdata[15:0];
					para[para_len].sx    = s_tdata[31:16];
					para[para_len].pen   = s_tdata[47:32];
					para[para_len].flags = s_tuser;
					para_len++;
				end
				if (s_tlast) begin
					if (para_len > 0)
						solve_paragraph();
					para_len = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (picks.size() == 0) begin
					report("unexpected beat, break_index", int'(m_tdata[5:0]), -1);
				end else begin
					exp_pick = picks.pop_front();
					if (m_tdata[5:0] != exp_pick.idx)
						report("break_index", int'(m_tdata[5:0]), int'(exp_pick.idx));
					if (m_tdata[7:6] != 2'b00)
						report("tdata pad", int'(m_tdata[7:6]), 0);
					if (m_tlast != exp_pick.last)
						report("last_of_run", int'(m_tlast), int'(exp_pick.last));
				end
			end
			pending <= picks.size();
		end
	end

endmodule

[dv/paragraph_line_break_optimizer_top_tb.sv]
// ----------------------------------------------------------------------------
// paragraph_line_break_optimizer_top_tb: line breaker testbench
// Directed paragraphs, then random paragraphs over several register settings,
// with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module paragraph_line_break_optimizer_top_tb;
	import plbo_pkg::*;

	localparam int QUIET_LIMIT = 200000;  // cycles without any beat
	localparam int ITEM_GOAL   = 160;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_START_OFFSET;
	logic [15:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int items_sent   = 0;
	bit no_idle      = 0;   // stretch with no idling on either side
	bit press_go     = 0;   // requests one long output hold-off
	bit press_done   = 0;
	int press_left   = 0;

	paragraph_line_break_optimizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	plbo_break_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog: the limit is generous even for a full 64 break solve
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("paragraph_line_break_optimizer_top_tb: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	always @(posedge clk) begin
		if (press_go && !press_done) begin
			press_done <= 1'b1;
			press_left <= 600;
			m_tready   <= 1'b0;
		end else if (press_left > 0) begin
			press_left <= press_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 18);
		end
	end

	// one break beat; ready is looked at mid-cycle, the beat lands on the next edge
	task send_break(input logic [15:0] ex, input logic [15:0] sx, input logic [15:0] pen,
	                input logic hyp, input logic hard, input logic last);
		while (!no_idle && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pen, sx, ex};
		s_tuser  <= {hard, hyp};
		s_tlast  <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items_sent++;
	endtask

	// registers move only once the block has drained
	task set_config(input logic [15:0] offset, input logic [14:0] ideal,
	                input logic [14:0] hyp_pen);
		s_tvalid <= 1'b0;
		// let the checker count the beats of a just-closed paragraph first
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_OFFSET;
		cfg_data  <= offset;
		@(posedge clk);
		cfg_index <= CFG_IDEAL_WIDTH;
		cfg_data  <= {1'b0, ideal};
		@(posedge clk);
		cfg_index <= CFG_HYPHEN_PAIR;
		cfg_data  <= {1'b0, hyp_pen};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly plausible word layouts, with some fully random beats mixed in
	task send_paragraph(input int n);
		int pos, k;
		pos = $urandom_range(0, 300);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 15) begin
				send_break(16'($urandom), 16'($urandom), 16'($urandom),
				           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				           k == n - 1);
			end else begin
				pos += $urandom_range(80, 1800);
				send_break(pos[15:0], pos[15:0] + 16'($urandom_range(0, 100)),
				           ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 800)) - 16'd400
				                                       : 16'd0,
				           $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0,
				           k == n - 1);
				pos += $urandom_range(0, 100);
			end
		end
	endtask

	initial begin
		int phase, budget;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		// single break: too wide, extreme fields
		send_break(16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0, 1'b1);
		// normal lines with a hyphen pair, a hard break and tied costs
		send_break(16'd2000, 16'd2100, 16'd0,    1'b1, 1'b0, 1'b0);
		send_break(16'd2400, 16'd2500, 16'd0,    1'b1, 1'b0, 1'b0);
		send_break(16'd4700, 16'd4800, 16'd400,  1'b0, 1'b0, 1'b0);
		send_break(16'd6900, 16'd7000, 16'd0,    1'b0, 1'b1, 1'b0);
		send_break(16'd9600, 16'd9700, 16'h7FFF, 1'b1, 1'b0, 1'b0);
		send_break(16'd9800, 16'd9800, 16'h8000, 1'b1, 1'b1, 1'b1);
		// nothing fits anywhere: forced overlong chain
		send_break(16'd10000, 16'd10000, 16'd0, 1'b0, 1'b0, 1'b0);
		send_break(16'd20000, 16'd20000, 16'd0, 1'b0, 1'b0, 1'b0);
		send_break(16'd30000, 16'd30000, 16'd0, 1'b0, 1'b0, 1'b1);
		// negative extremes and a hard break first
		send_break(16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0);
		send_break(16'hFF00, 16'h0000, 16'h8000, 1'b1, 1'b0, 1'b0);
		send_break(16'h0100, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 1'b1);
		// hyphen pair penalty with the register at its top
		set_config(16'h0000, 15'd3000, 15'h7FFF);
		send_break(16'd1500, 16'd1500, 16'd0, 1'b1, 1'b0, 1'b0);
		send_break(16'd2900, 16'd2900, 16'd0, 1'b1, 1'b0, 1'b0);
		send_break(16'd3000, 16'd3000, 16'd0, 1'b1, 1'b0, 1'b1);

		// random phases over register settings, extremes among them
		phase = 0;
		while (phase < 5 || items_sent < ITEM_GOAL) begin
			case (phase % 5)
				0: set_config(16'($urandom_range(0, 600)) - 16'd300,
				              15'($urandom_range(2000, 9000)), 15'($urandom_range(0, 3000)));
				1: set_config(16'h8000, 15'h7FFF, 15'h7FFF);
				2: set_config(16'h7FFF, 15'd0, 15'd0);
				3: set_config(16'd0, 15'($urandom_range(3000, 6000)), 15'($urandom));
				default: set_config(16'($urandom), 15'($urandom), 15'($urandom));
			endcase
			no_idle  = (phase == 3);
			press_go = (phase >= 1);
			if (phase == 3) begin
				send_paragraph(64);
			end else if (phase == 4) begin
				send_paragraph(66);  // overflow: beats past the store are dropped
			end else begin
				budget = items_sent + 4;
				while (items_sent < budget)
					send_paragraph(($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
					                                          : $urandom_range(1, 12));
			end
			no_idle = 0;
			phase++;
		end
		s_tvalid <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("paragraph_line_break_optimizer_top_tb: clean");
		else
			$display("paragraph_line_break_optimizer_top_tb: errors");
		$finish;
	end

endmodule

[files.f]
sv/plbo_pkg.sv
sv/plbo_ram.sv
sv/plbo_line_cost.sv
sv/paragraph_line_break_optimizer_top.sv
dv/plbo_break_checker.sv
dv/paragraph_line_break_optimizer_top_tb.sv
